// File: rtl/u16u8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  // Values of the byte order mode register.
  localparam logic [1:0] MODE_LITTLE  = 2'd0;
  localparam logic [1:0] MODE_SWAP    = 2'd1;
  localparam logic [1:0] MODE_BOM     = 2'd2;
  localparam logic [1:0] MODE_BOM_ALT = 2'd3;

  localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
  localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_MAX   = 16'h07FF;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One queued job: up to four bytes, first byte in bytes[0].
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;  // 1..4
    logic            bare;    // end marker without data
    logic            eos;     // caused by the last unit of a string
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/u16u8_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [15:0]            in_tdata,
  input  wire logic                   in_tlast,
  input  wire u16u8_pkg::queue_status_t q_status,
  output logic                        push,
  output u16u8_pkg::job_t             push_job
);

  logic [1:0] mode_r;
  logic       at_first_r;
  logic       swap_r;
  logic       discard_r;
  logic       pend_r;
  logic [9:0] high_bits_r;

  logic       accept;
  logic       bom_mode;
  logic       swap;
  logic       discard;
  logic       pend;
  logic [15:0] w;
  logic [20:0] cp;
  logic [2:0] n;
  logic [3:0][7:0] bytes;
  logic       set_pend;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  assign bom_mode = (mode_r == u16u8_pkg::MODE_BOM) || (mode_r == u16u8_pkg::MODE_BOM_ALT);

  always_comb begin
    if (at_first_r) begin
      pend = 1'b0;
      if (bom_mode) begin
        swap    = (in_tdata == u16u8_pkg::BOM_SWAPPED);
        discard = (in_tdata != u16u8_pkg::BOM_NATIVE) && (in_tdata != u16u8_pkg::BOM_SWAPPED);
      end else begin
        swap    = (mode_r == u16u8_pkg::MODE_SWAP);
        discard = 1'b0;
      end
    end else begin
      pend    = pend_r;
      swap    = swap_r;
      discard = discard_r;
    end
  end

  assign w  = swap ? {in_tdata[7:0], in_tdata[15:8]} : in_tdata;
  assign cp = u16u8_pkg::SUPPLEMENTARY_BASE + {1'b0, high_bits_r, w[9:0]};

  always_comb begin
    n        = 3'd0;
    bytes    = '0;
    set_pend = 1'b0;
    if (discard) begin
      n = 3'd0;
    end else if (at_first_r && (w == u16u8_pkg::BOM_NATIVE)) begin
      n = 3'd0;
    end else if (pend) begin
      n        = 3'd4;
      bytes[0] = u16u8_pkg::LEAD_FOUR | {5'd0, cp[20:18]};
      bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, cp[17:12]};
      bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
      bytes[3] = u16u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
    end else if (w inside {[u16u8_pkg::HIGH_SURR_MIN:u16u8_pkg::HIGH_SURR_MAX]}) begin
      set_pend = !in_tlast;
    end else if (w < u16u8_pkg::ONE_BYTE_LIMIT) begin
      n        = 3'd1;
      bytes[0] = w[7:0];
    end else if (w <= u16u8_pkg::TWO_BYTE_MAX) begin
      n        = 3'd2;
      bytes[0] = u16u8_pkg::LEAD_TWO | {3'd0, w[10:6]};
      bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, w[5:0]};
    end else begin
      n        = 3'd3;
      bytes[0] = u16u8_pkg::LEAD_THREE | {4'd0, w[15:12]};
      bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, w[11:6]};
      bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, w[5:0]};
    end
  end

  // A unit without bytes is queued only when it ends a string, as a bare marker.
  assign push            = accept && ((n != 3'd0) || in_tlast);
  assign push_job.bytes  = bytes;
  assign push_job.nbytes = (n == 3'd0) ? 3'd1 : n;
  assign push_job.bare   = (n == 3'd0);
  assign push_job.eos    = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= u16u8_pkg::MODE_LITTLE;
      at_first_r <= 1'b1;
      swap_r     <= 1'b0;
      discard_r  <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (accept) begin
        at_first_r <= in_tlast;
        swap_r     <= swap;
        discard_r  <= discard && !in_tlast;
        pend_r     <= set_pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && set_pend) begin
      high_bits_r <= w[9:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/u16u8_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire u16u8_pkg::job_t         push_job,
  input  wire logic                    pop,
  output u16u8_pkg::job_t              head_job,
  output u16u8_pkg::queue_status_t     status
);

  u16u8_pkg::job_t entries [u16u8_pkg::QUEUE_DEPTH];

  logic [u16u8_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [u16u8_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [u16u8_pkg::QUEUE_AW:0]   count_r;

  assign status.full  = (count_r == (u16u8_pkg::QUEUE_AW+1)'(u16u8_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_job     = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/u16u8_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire u16u8_pkg::job_t         head_job,
  input  wire u16u8_pkg::queue_status_t q_status,
  output logic                         pop,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [7:0]                   out_tdata,
  output logic                         out_tlast,
  output logic [1:0]                   out_tuser
);

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       bvalid_r;
  logic       eos_r;
  logic [1:0] idx_r;

  logic slot_free;
  logic take;
  logic final_byte;

  assign slot_free  = !out_valid_r || out_tready;
  assign take       = slot_free && !q_status.empty;
  assign final_byte = ({1'b0, idx_r} == (head_job.nbytes - 3'd1));
  assign pop        = take && final_byte;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {eos_r, bvalid_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (slot_free) begin
        out_valid_r <= !q_status.empty;
      end
      if (take) begin
        idx_r <= final_byte ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r   <= head_job.bare ? 8'd0 : head_job.bytes[idx_r];
      bvalid_r <= !head_job.bare;
      last_r   <= final_byte;
      eos_r    <= final_byte && head_job.eos;
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-16 to UTF-8 transcoder. Each input transaction carries one UTF-16 code
// unit in in_tdata, with in_tlast marking the last unit of a string; each output
// transaction carries one UTF-8 byte. The front end classifies a unit in the
// cycle it is accepted (byte order, BOM strip, surrogate pairing) and queues a
// job of one to four bytes in a four-entry queue; the back end sends one byte
// per cycle through a registered output while out_tready does not stall it.
// A Basic Multilingual Plane unit produces one to three bytes and a surrogate
// pair four; a unit that produces no bytes sends nothing unless it ends a string.
// The byte order mode (cfg_data: 0 little endian, 1 byte swapped, 2 or 3 chosen
// by a leading BOM) is sampled at the first unit of each string; in BOM mode a
// string without a BOM produces no bytes. A unit that produces no bytes but ends
// a string yields a bare end marker with the byte valid flag low.
module utf16_to_utf8_transcoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel: byte_order_mode.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] code_unit
  input  wire logic        in_tlast,   // last_unit
  // Output stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] utf8_byte
  output logic             out_tlast,  // last_of_run
  output logic [1:0]       out_tuser   // [0] byte_valid, [1] end_of_string
);

  u16u8_pkg::queue_status_t q_status;
  u16u8_pkg::job_t          push_job;
  u16u8_pkg::job_t          head_job;
  logic                     push;
  logic                     pop;

  // Front end: configuration register, per-string state and byte generation.
  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  // Job queue that decouples unit acceptance from byte delivery.
  u16u8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Back end: serializes each job onto the output stream, one byte per cycle while out_tready allows.
  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
